@@ sv/sine_unit_deg_rad_defines.svh @@
// ----------------------------------------------------------------------------
// Sine unit assertion macros
// Shared property macros for the port checker of the sine unit.
// ----------------------------------------------------------------------------
`ifndef SINE_UNIT_DEG_RAD_DEFINES_SVH
`define SINE_UNIT_DEG_RAD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SUD_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sine unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SUD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sine unit check failed");

`endif

@@ sv/sud_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine unit package
// Fixed-point constants, the arctangent table and the control word that
// travels beside the data through every cell of the sine unit.
// ----------------------------------------------------------------------------
package sud_pkg;

	// Pi in Q.60, rounded down.
	localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

	// Pi/180 in Q0.64, truncated.
	localparam logic [63:0] Deg2RadQ64 = ((PiQ60 / 64'd180) << 4)
		+ ((((PiQ60 % 64'd180) << 4) + 64'd3) / 64'd180);

	// Pi and pi/2 in Q.30, rounded half up.
	localparam logic [31:0] PiQ30     = 32'((PiQ60 + (64'd1 << 29)) >> 30);
	localparam logic [31:0] HalfPiQ30 = 32'((PiQ60 + (64'd1 << 30)) >> 31);

	// CORDIC datapath widths: x and y, and the residual angle.
	localparam int XyWidth = 33;
	localparam int ZWidth  = 34;

	// Start vector x, the reciprocal of the limit of the CORDIC gain, in Q.30.
	localparam logic signed [XyWidth-1:0] CordicGainQ30 = 652032874;

	// Arctangent of 2^-i in Q.30, rounded.
	localparam int AtanEntries = 32;
	localparam logic [31:0] AtanQ30 [AtanEntries] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128,
		32'd64,        32'd32,        32'd16,        32'd8,
		32'd4,         32'd2,         32'd1,         32'd0
	};

	// Control word carried alongside each transaction.
	typedef struct packed {
		logic valid;
		logic degree;
		logic neg;
		logic zero;
	} ctl_t;

	// Pi at the input angle scale, rounded half up.
	function automatic logic [63:0] pi_fix(input int frac);
		logic [63:0] rs;
		rs = 64'd1 << (59 - frac);
		return (PiQ60 + rs) >> (60 - frac);
	endfunction

	// Two pi at the input angle scale, rounded half up.
	function automatic logic [63:0] two_pi_fix(input int frac);
		logic [63:0] rs;
		rs = 64'd1 << (59 - frac);
		return ((PiQ60 << 1) + rs) >> (60 - frac);
	endfunction

endpackage

@@ sv/sud_mod_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine unit reduction cell
// One step of the restoring remainder: subtracts the full-turn constant,
// shifted by this cell's position, when the magnitude is at least that large.
// ----------------------------------------------------------------------------
module sud_mod_cell #(
	parameter int ANGLE_WIDTH     = 32,
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int SHIFT           = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  sud_pkg::ctl_t          up_ctl,
	input  logic [ANGLE_WIDTH-1:0] up_mag,
	output sud_pkg::ctl_t          ctl,
	output logic [ANGLE_WIDTH-1:0] mag
);
	import sud_pkg::*;

	localparam int CmpWidth = ANGLE_WIDTH + 8;
	localparam logic [CmpWidth-1:0] DegStep =
		CmpWidth'(360) << (ANGLE_FRAC_BITS + SHIFT);
	localparam logic [CmpWidth-1:0] RadStep =
		CmpWidth'(two_pi_fix(ANGLE_FRAC_BITS)) << SHIFT;

	logic [CmpWidth-1:0]    step;
	logic                   take;
	ctl_t                   ctl_q;
	logic [ANGLE_WIDTH-1:0] mag_q;

	// Compare against the scaled full turn of the selected unit.
	assign step = up_ctl.degree ? DegStep : RadStep;
	assign take = {8'd0, up_mag} >= step;

	// Control word moves to the neighbor on every advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= up_ctl;
		end
	end

	// Conditional subtraction of the partial remainder.
	always_ff @(posedge clk) begin
		if (advance) begin
			mag_q <= take ? up_mag - step[ANGLE_WIDTH-1:0] : up_mag;
		end
	end

	assign ctl = ctl_q;
	assign mag = mag_q;

endmodule

@@ sv/sud_to_rad.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine unit angle conversion
// Detects the exact-zero angles, folds the reduced angle into the first
// quadrant and brings it to radians in Q.30 over five register stages.
// ----------------------------------------------------------------------------
module sud_to_rad #(
	parameter int ANGLE_WIDTH     = 32,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  sud_pkg::ctl_t                     up_ctl,
	input  logic [ANGLE_WIDTH-1:0]            up_mag,
	output sud_pkg::ctl_t                     ctl,
	output logic signed [sud_pkg::ZWidth-1:0] rad
);
	import sud_pkg::*;

	localparam int ConvWidth = (ANGLE_FRAC_BITS + 9 > 33) ? ANGLE_FRAC_BITS + 9 : 33;
	localparam int ProdWidth = ConvWidth + 64;
	localparam int RadShift  = 30 - ANGLE_FRAC_BITS;

	localparam logic [ConvWidth-1:0] DegHalf     = ConvWidth'(180) << ANGLE_FRAC_BITS;
	localparam logic [ConvWidth-1:0] DegQuarter  = ConvWidth'(90) << ANGLE_FRAC_BITS;
	localparam logic [ConvWidth-1:0] RadZeroHalf =
		ConvWidth'(pi_fix(ANGLE_FRAC_BITS)) << RadShift;
	localparam logic [ConvWidth-1:0] RadHalf     = ConvWidth'(PiQ30);
	localparam logic [ConvWidth-1:0] RadQuarter  = ConvWidth'(HalfPiQ30);
	localparam logic [31:0]          MulLo       = Deg2RadQ64[31:0];
	localparam logic [31:0]          MulHi       = Deg2RadQ64[63:32];
	localparam logic [ProdWidth-1:0] RoundBit    =
		ProdWidth'(1) << (33 + ANGLE_FRAC_BITS);

	logic [ConvWidth-1:0]    m_ext;
	logic [ConvWidth-1:0]    a_in;
	logic [ConvWidth-1:0]    half_in;
	logic [ConvWidth-1:0]    zero_half;
	logic                    ge_half;
	logic [ConvWidth-1:0]    quarter_s1;
	logic [ConvWidth-1:0]    half_s1;
	logic [ConvWidth-1:0]    fold_s1;
	logic [ProdWidth-1:0]    prod_sum;
	ctl_t                    ctl_in;

	ctl_t                    ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [ConvWidth-1:0]    a_s1, a_s2, a_s3, a_s4;
	logic [ConvWidth+31:0]   p_lo_s3, p_lo_s4;
	logic [ConvWidth+31:0]   p_hi_s4;
	logic signed [ZWidth-1:0] rad_s5;

	// Radian angles move to Q.30; degree angles stay at the input scale.
	assign m_ext     = ConvWidth'(up_mag);
	assign a_in      = up_ctl.degree ? m_ext : (m_ext << RadShift);
	assign zero_half = up_ctl.degree ? DegHalf : RadZeroHalf;
	assign half_in   = up_ctl.degree ? DegHalf : RadHalf;
	assign ge_half   = a_in >= half_in;

	// Exact zero at zero and at a half turn; half-turn fold flips the sign.
	always_comb begin
		ctl_in      = up_ctl;
		ctl_in.zero = (a_in == '0) || (a_in == zero_half);
		ctl_in.neg  = up_ctl.neg ^ ge_half;
	end

	// Quarter-turn fold; radian overshoot past pi clamps to pi, which folds to zero.
	assign quarter_s1 = ctl_s1.degree ? DegQuarter : RadQuarter;
	assign half_s1    = ctl_s1.degree ? DegHalf : RadHalf;
	always_comb begin
		priority if (a_s1 > half_s1) begin
			fold_s1 = '0;
		end else if (a_s1 > quarter_s1) begin
			fold_s1 = half_s1 - a_s1;
		end else begin
			fold_s1 = a_s1;
		end
	end

	// Full product of the folded degree angle and pi/180, rounded half up.
	assign prod_sum = {p_hi_s4, 32'd0} + ProdWidth'(p_lo_s4) + RoundBit;

	// Control words of the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Datapath: two folds, two partial products, then the rounded sum.
	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1    <= ge_half ? a_in - half_in : a_in;
			a_s2    <= fold_s1;
			a_s3    <= a_s2;
			p_lo_s3 <= (ConvWidth + 32)'(a_s2) * (ConvWidth + 32)'(MulLo);
			a_s4    <= a_s3;
			p_lo_s4 <= p_lo_s3;
			p_hi_s4 <= (ConvWidth + 32)'(a_s3) * (ConvWidth + 32)'(MulHi);
			rad_s5  <= ctl_s4.degree ? ZWidth'(prod_sum >> (34 + ANGLE_FRAC_BITS))
			                         : ZWidth'(a_s4);
		end
	end

	assign ctl = ctl_s5;
	assign rad = rad_s5;

endmodule

@@ sv/sud_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine unit CORDIC cell
// One rotation-mode CORDIC micro-rotation with a fixed shift and a fixed
// arctangent constant, registered toward the next cell.
// ----------------------------------------------------------------------------
module sud_cordic_cell #(
	parameter int ITER = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  sud_pkg::ctl_t                      up_ctl,
	input  logic signed [sud_pkg::XyWidth-1:0] up_x,
	input  logic signed [sud_pkg::XyWidth-1:0] up_y,
	input  logic signed [sud_pkg::ZWidth-1:0]  up_z,
	output sud_pkg::ctl_t                      ctl,
	output logic signed [sud_pkg::XyWidth-1:0] x,
	output logic signed [sud_pkg::XyWidth-1:0] y,
	output logic signed [sud_pkg::ZWidth-1:0]  z
);
	import sud_pkg::*;

	localparam logic signed [ZWidth-1:0] Atan = ZWidth'(AtanQ30[ITER]);

	logic signed [XyWidth-1:0] dx;
	logic signed [XyWidth-1:0] dy;
	logic                      rot_pos;
	ctl_t                      ctl_q;
	logic signed [XyWidth-1:0] x_q;
	logic signed [XyWidth-1:0] y_q;
	logic signed [ZWidth-1:0]  z_q;

	// Floor shifts and rotation direction from the residual angle's sign.
	assign dx      = up_y >>> ITER;
	assign dy      = up_x >>> ITER;
	assign rot_pos = !up_z[ZWidth-1];

	// Control word follows the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= up_ctl;
		end
	end

	// Micro-rotation.
	always_ff @(posedge clk) begin
		if (advance) begin
			x_q <= rot_pos ? up_x - dx : up_x + dx;
			y_q <= rot_pos ? up_y + dy : up_y - dy;
			z_q <= rot_pos ? up_z - Atan : up_z + Atan;
		end
	end

	assign ctl = ctl_q;
	assign x   = x_q;
	assign y   = y_q;
	assign z   = z_q;

endmodule

@@ sv/sine_unit_deg_rad.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine unit with degree or radian input
// Reduces a signed Q15.16 angle by a truncated remainder of a full turn,
// folds it into the first quadrant and returns its sine in signed Q1.16.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------
//  input     angle_valid / angle_stall angle       (signed Q15.16)
//  output    sine_valid / sine_stall   sine_value  (signed Q1.16)
//  config    cfg_we                    cfg_wdata   (degree_mode)
//
//  One transaction is taken every cycle while angle_stall is low. The row has
//  R reduction cells (ANGLE_WIDTH - ANGLE_FRAC_BITS - 2, at least one) and
//  N CORDIC cells (CORDIC_ITERATIONS, at most 32).
//  Reset is asynchronous and active low; degree_mode resets to degrees.
//  A result waiting under sine_stall parks in a skid register; angle_stall
//  rises only while that skid register is full, and the whole row holds.
//
module sine_unit_deg_rad #(
	parameter int ANGLE_WIDTH       = 32,
	parameter int ANGLE_FRAC_BITS   = 16,
	parameter int SINE_FRAC_BITS    = 16,
	parameter int CORDIC_ITERATIONS = 18
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           angle_valid,
	output logic                           angle_stall,
	input  logic signed [ANGLE_WIDTH-1:0]  angle,
	output logic                           sine_valid,
	input  logic                           sine_stall,
	output logic signed [SINE_FRAC_BITS+1:0] sine_value
);
	import sud_pkg::*;

	localparam int RedCells    = (ANGLE_WIDTH - ANGLE_FRAC_BITS - 2 > 1)
		? ANGLE_WIDTH - ANGLE_FRAC_BITS - 2 : 1;
	localparam int CordicCells = (CORDIC_ITERATIONS < AtanEntries)
		? CORDIC_ITERATIONS : AtanEntries;
	localparam int SineWidth   = SINE_FRAC_BITS + 2;
	localparam int RndShift    = (SINE_FRAC_BITS < 30) ? 29 - SINE_FRAC_BITS : 0;
	localparam logic signed [XyWidth-1:0] RoundAdd = (SINE_FRAC_BITS < 30)
		? (XyWidth'(1) << RndShift) : '0;
	localparam logic signed [SineWidth:0] SatMax = (SineWidth + 1)'(1) << SINE_FRAC_BITS;
	localparam logic signed [SineWidth:0] SatMin = -SatMax;

	logic                      degree_mode_q;
	logic                      advance;
	ctl_t                      ctl_s1;
	logic [ANGLE_WIDTH-1:0]    mag_s1;

	ctl_t                      red_ctl [RedCells+1];
	logic [ANGLE_WIDTH-1:0]    red_mag [RedCells+1];

	ctl_t                      rad_ctl;
	logic signed [ZWidth-1:0]  rad_z;

	ctl_t                      cor_ctl [CordicCells+1];
	logic signed [XyWidth-1:0] cor_x   [CordicCells+1];
	logic signed [XyWidth-1:0] cor_y   [CordicCells+1];
	logic signed [ZWidth-1:0]  cor_z   [CordicCells+1];

	logic signed [XyWidth-1:0] y_round;
	logic signed [SineWidth:0] signed_y;
	logic signed [SineWidth:0] sat_y;
	ctl_t                      ctl_s2, ctl_s3;
	logic signed [SineWidth:0] y_s2;
	logic [SineWidth-1:0]      sine_s3;

	logic                      push;
	logic                      take;
	logic                      out_valid_q;
	logic [SineWidth-1:0]      out_data_q;
	logic                      skid_valid_q;
	logic [SineWidth-1:0]      skid_data_q;

	// The row moves whenever the skid register is free.
	assign advance     = !skid_valid_q;
	assign angle_stall = skid_valid_q;

	// Degree-mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_mode_q <= 1'b1;
		end else if (cfg_we) begin
			degree_mode_q <= cfg_wdata;
		end
	end

	// Input stage: capture mode and sign, take the exact magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= '{valid: angle_valid, degree: degree_mode_q,
			            neg: angle[ANGLE_WIDTH-1], zero: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1 <= angle[ANGLE_WIDTH-1] ? $unsigned(-angle) : $unsigned(angle);
		end
	end

	// Row of reduction cells, largest multiple of the full turn first.
	assign red_ctl[0] = ctl_s1;
	assign red_mag[0] = mag_s1;

	for (genvar i = 0; i < RedCells; i++) begin : g_red
		sud_mod_cell #(
			.ANGLE_WIDTH    (ANGLE_WIDTH),
			.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
			.SHIFT          (RedCells - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.up_ctl (red_ctl[i]),
			.up_mag (red_mag[i]),
			.ctl    (red_ctl[i+1]),
			.mag    (red_mag[i+1])
		);
	end

	// Zero detection, quadrant fold and conversion to radians.
	sud_to_rad #(
		.ANGLE_WIDTH    (ANGLE_WIDTH),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_to_rad (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.up_ctl (red_ctl[RedCells]),
		.up_mag (red_mag[RedCells]),
		.ctl    (rad_ctl),
		.rad    (rad_z)
	);

	// Row of CORDIC cells, one per iteration.
	assign cor_ctl[0] = rad_ctl;
	assign cor_x[0]   = CordicGainQ30;
	assign cor_y[0]   = '0;
	assign cor_z[0]   = rad_z;

	for (genvar i = 0; i < CordicCells; i++) begin : g_cordic
		sud_cordic_cell #(
			.ITER(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.up_ctl (cor_ctl[i]),
			.up_x   (cor_x[i]),
			.up_y   (cor_y[i]),
			.up_z   (cor_z[i]),
			.ctl    (cor_ctl[i+1]),
			.x      (cor_x[i+1]),
			.y      (cor_y[i+1]),
			.z      (cor_z[i+1])
		);
	end

	// Round y half up to the output scale.
	assign y_round = (cor_y[CordicCells] + RoundAdd) >>> (30 - SINE_FRAC_BITS);

	// Apply the sign, saturate to one, force exact zeros.
	assign signed_y = ctl_s2.neg ? -y_s2 : y_s2;
	always_comb begin
		priority if (ctl_s2.zero) begin
			sat_y = '0;
		end else if (signed_y > SatMax) begin
			sat_y = SatMax;
		end else if (signed_y < SatMin) begin
			sat_y = SatMin;
		end else begin
			sat_y = signed_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (advance) begin
			ctl_s2 <= cor_ctl[CordicCells];
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2    <= (SineWidth + 1)'(y_round);
			sine_s3 <= sat_y[SineWidth-1:0];
		end
	end

	// Output register with a skid register behind it.
	assign push = ctl_s3.valid && advance;
	assign take = out_valid_q && !sine_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_data_q <= skid_valid_q ? skid_data_q : sine_s3;
		end else if (push) begin
			skid_data_q <= sine_s3;
		end
	end

	assign sine_valid = out_valid_q;
	assign sine_value = out_data_q;

endmodule

@@ sv/sud_port_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine unit port checker
// Watches the ports of the sine unit for stall, skid and output range rules.
// ----------------------------------------------------------------------------
`include "sine_unit_deg_rad_defines.svh"

module sud_port_checker #(
	parameter int SINE_FRAC_BITS = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            angle_valid,
	input logic                            angle_stall,
	input logic                            sine_valid,
	input logic                            sine_stall,
	input logic signed [SINE_FRAC_BITS+1:0] sine_value
);
	localparam int SineWidth = SINE_FRAC_BITS + 2;
	localparam logic signed [SineWidth-1:0] SineMax = SineWidth'(1) << SINE_FRAC_BITS;
	localparam logic signed [SineWidth-1:0] SineMin = -SineMax;

	logic in_wait;

	// An input transaction that is held back.
	assign in_wait = angle_valid && angle_stall;

	// Input stall only while a result is on offer at the output.
	`SUD_ASSERT_IMPLY(a_stall_has_output, clk, arst_n, angle_stall || in_wait, sine_valid)

	// Input stall rises only after a stalled result.
	`SUD_ASSERT_IMPLY(a_stall_rise, clk, arst_n, $rose(angle_stall), $past(sine_valid) && $past(sine_stall))

	// The skid register cannot drain while the output stays stalled.
	`SUD_ASSERT_NEXT(a_stall_holds, clk, arst_n, angle_stall && sine_stall, angle_stall)

	// A stalled result holds.
	`SUD_ASSERT_NEXT(a_out_hold, clk, arst_n, sine_valid && sine_stall, sine_valid && $stable(sine_value))

	// Results stay within plus and minus one.
	`SUD_ASSERT_IMPLY(a_out_range, clk, arst_n, sine_valid, sine_value <= SineMax && sine_value >= SineMin)

endmodule

bind sine_unit_deg_rad sud_port_checker #(
	.SINE_FRAC_BITS(SINE_FRAC_BITS)
) u_port_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.angle_valid(angle_valid),
	.angle_stall(angle_stall),
	.sine_valid (sine_valid),
	.sine_stall (sine_stall),
	.sine_value (sine_value)
);
